/* rtl/ffl_pkg.sv */
// ffl_pkg: shared constants, types and tables for the fog factor table entry block
// depends on nothing; used by ffl_div, ffl_exp, fog_factor_lut_entry and the dv checker and bench
package ffl_pkg;

    localparam int IDX_W             = 7;
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int Z_DEPTH           = (1 << IDX_W) + 1;
    localparam int ZI_W              = $clog2(Z_DEPTH);
    localparam int Z_W               = 27;
    localparam int F_W               = 17;
    localparam int T_W               = 35;
    localparam int WORD_W            = 24;
    localparam int DIV_STAGES        = 17;
    localparam int EXP_STAGES        = 5;
    localparam int PAD_STAGES        = DIV_STAGES - EXP_STAGES;

    // eye distance numerator 2000 * 65536 (times entries), denominator factor
    localparam longint unsigned NUM_SCALE = 64'd131072000;
    localparam longint unsigned DEN_MUL   = 64'd19999;

    localparam logic [16:0] LOG2E   = 17'd94548;
    localparam logic [15:0] LN2     = 16'd45426;
    localparam logic [F_W-1:0] F_ONE = 17'd65536;

    localparam logic [10:0] VAL_MAX   = 11'h7FF;
    localparam logic signed [17:0] DELTA_MIN = -18'sd4096;
    localparam logic signed [17:0] DELTA_MAX = 18'sd4095;
    localparam int VAL_SHIFT = 13;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_EXP    = 2'd1,
        MODE_OFF    = 2'd2,
        MODE_SPARE  = 2'd3
    } fog_mode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_START   = 2'd1,
        REG_END     = 2'd2,
        REG_DENSITY = 2'd3
    } cfg_reg_t;

    // linear fog outcome decided before the divider
    typedef enum logic [1:0] {
        LIN_ONE  = 2'd0,
        LIN_ZERO = 2'd1,
        LIN_DIV  = 2'd2
    } lin_cls_t;

    function automatic logic [15:0] pow2_frac(input logic [3:0] j);
        logic [15:0] r;
        begin
            case (j)
                4'd0:    r = 16'd0;      // stands for 65536, handled by caller
                4'd1:    r = 16'd62757;
                4'd2:    r = 16'd60097;
                4'd3:    r = 16'd57549;
                4'd4:    r = 16'd55109;
                4'd5:    r = 16'd52773;
                4'd6:    r = 16'd50535;
                4'd7:    r = 16'd48393;
                4'd8:    r = 16'd46341;
                4'd9:    r = 16'd44376;
                4'd10:   r = 16'd42495;
                4'd11:   r = 16'd40693;
                4'd12:   r = 16'd38968;
                4'd13:   r = 16'd37316;
                4'd14:   r = 16'd35734;
                default: r = 16'd34219;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] pow2_tab(input logic [3:0] j);
        logic [16:0] r;
        begin
            r = (j == 4'd0) ? 17'd65536 : {1'b0, pow2_frac(j)};
            return r;
        end
    endfunction

endpackage

/* rtl/ffl_div.sv */
// ffl_div: pipelined restoring divider, one quotient bit per stage
// depends on ffl_pkg; quotient known to stay below 2^17
module ffl_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [31:0]               num,
    input  logic [31:0]               den,
    output logic [ffl_pkg::F_W-1:0]   quo
);
    import ffl_pkg::*;

    localparam int R_W = 48;

    logic [R_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [31:0]    den_reg [0:DIV_STAGES-1];
    logic [F_W-1:0] quo_reg [0:DIV_STAGES-1];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        localparam int B = DIV_STAGES - 1 - g;
        logic [R_W-1:0] rem_in;
        logic [31:0]    den_in;
        logic [F_W-1:0] quo_in;
        logic [R_W:0]   trial;
        logic           fits;

        if (g == 0) begin : g_first
            assign rem_in = {num, 16'd0};
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        // trial subtract of the divisor at this bit weight
        assign trial = {1'b0, rem_in} - ({17'd0, den_in} << B);
        assign fits  = ~trial[R_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= fits ? trial[R_W-1:0] : rem_in;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_in | (F_W'(fits) << B);
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

/* rtl/ffl_exp.sv */
// ffl_exp: pipelined exp(-t) in Q.16 via base-2 split, table and quadratic tail
// depends on ffl_pkg; registers advance only under enable
module ffl_exp (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ffl_pkg::T_W-1:0]   t,
    output logic [ffl_pkg::F_W-1:0]   f
);
    import ffl_pkg::*;

    logic [35:0]    u_reg;
    logic [51:0]    u_prod;
    logic [11:0]    a_reg;
    logic [27:0]    a_prod;
    logic [3:0]     j1_reg, j2_reg;
    logic [4:0]     n1_reg, n2_reg, n3_reg;
    logic           z1_reg, z2_reg, z3_reg;
    logic [16:0]    tail_reg;
    logic [16:0]    tail_next;
    logic [23:0]    a_sq;
    logic [33:0]    p_prod;
    logic [16:0]    p_reg;
    logic [F_W-1:0] f_reg;

    assign u_prod    = 52'(t) * 52'(LOG2E);
    assign a_prod    = 28'(u_reg[11:0]) * 28'(LN2);
    assign a_sq      = 24'(a_reg) * 24'(a_reg);
    assign tail_next = 17'd65536 - 17'(a_reg) + 17'(a_sq >> 17);
    // table index sits in the same stage as the tail register
    assign p_prod    = 34'(pow2_tab(j2_reg)) * 34'(tail_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // exponent in base 2
            u_reg    <= u_prod[51:16];
            // fraction times ln2, split of integer part
            a_reg    <= a_prod[27:16];
            j1_reg   <= u_reg[15:12];
            n1_reg   <= u_reg[20:16];
            z1_reg   <= (u_reg[35:16] >= 20'd17);
            // quadratic tail
            tail_reg <= tail_next;
            j2_reg   <= j1_reg;
            n2_reg   <= n1_reg;
            z2_reg   <= z1_reg;
            // table product
            p_reg    <= p_prod[32:16];
            n3_reg   <= n2_reg;
            z3_reg   <= z2_reg;
            // integer shift
            f_reg    <= z3_reg ? '0 : (p_reg >> n3_reg);
        end
    end

    assign f = f_reg;

endmodule

/* rtl/fog_factor_lut_entry.sv */
// fog_factor_lut_entry: top level, fog table word for one entry index per cycle unless a result is held
// depends on ffl_pkg, ffl_div and ffl_exp
//
// path: stage a, stage b, the divider stages, then the register that drives table_word
// throughput: one request per cycle; the whole pipeline holds while a valid result is stalled at the output
// the 17-stage linear divider sets the depth; exp path is padded to match
// reset: valid bits clear, fog_mode 0, fog_start 0, fog_end 1.0, fog_density 1.0
module fog_factor_lut_entry #(
    parameter int TABLE_ENTRIES = ffl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ffl_pkg::IDX_W-1:0]     entry_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ffl_pkg::WORD_W-1:0]    table_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import ffl_pkg::*;

    // configuration registers
    logic [1:0]  fog_mode_reg;
    logic [31:0] fog_start_reg;
    logic [31:0] fog_end_reg;
    logic [23:0] fog_density_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fog_mode_reg    <= 2'd0;
            fog_start_reg   <= 32'd0;
            fog_end_reg     <= 32'd65536;
            fog_density_reg <= 24'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:    fog_mode_reg    <= cfg_data[1:0];
                REG_START:   fog_start_reg   <= cfg_data;
                REG_END:     fog_end_reg     <= cfg_data;
                REG_DENSITY: fog_density_reg <= cfg_data[23:0];
                default:     fog_mode_reg    <= fog_mode_reg;
            endcase
        end
    end

    // global advance: everything moves unless a finished result is held
    logic en;
    assign en       = ~(out_valid && out_stall);
    assign in_stall = ~en;

    // eye distance per depth step, worked out at elaboration
    logic [Z_W-1:0] z_tab [0:Z_DEPTH-1];
    for (genvar g = 0; g < Z_DEPTH; g++) begin : g_z
        localparam longint unsigned ZV =
            (NUM_SCALE * longint'(TABLE_ENTRIES)) /
            (DEN_MUL * longint'(g) + longint'(TABLE_ENTRIES));
        assign z_tab[g] = Z_W'(ZV);
    end

    // stage a: distance lookup for k and k+1
    logic           va_reg;
    logic [Z_W-1:0] z0_reg, z1_reg;
    logic [ZI_W-1:0] ia, ib;

    assign ia = ZI_W'(entry_index);
    assign ib = ZI_W'(entry_index) + ZI_W'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= z_tab[ia];
            z1_reg <= z_tab[ib];
        end
    end

    // stage b: linear classification, divider operands, density product
    logic           vb_reg;
    lin_cls_t       c0_reg, c1_reg;
    logic [31:0]    n0_reg, n1_reg, dd_reg;
    logic [T_W-1:0] t0_reg, t1_reg;
    lin_cls_t       c0_next, c1_next;
    logic [50:0]    tp0, tp1;

    function automatic lin_cls_t classify(input logic [Z_W-1:0] z,
                                          input logic [31:0] st,
                                          input logic [31:0] en_d);
        lin_cls_t c;
        begin
            if (32'(z) < st)
                c = LIN_ONE;
            else if (32'(z) > en_d || en_d <= st)
                c = LIN_ZERO;
            else
                c = LIN_DIV;
            return c;
        end
    endfunction

    assign c0_next = classify(z0_reg, fog_start_reg, fog_end_reg);
    assign c1_next = classify(z1_reg, fog_start_reg, fog_end_reg);
    assign tp0     = 51'(fog_density_reg) * 51'(z0_reg);
    assign tp1     = 51'(fog_density_reg) * 51'(z1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            n0_reg <= fog_end_reg - 32'(z0_reg);
            n1_reg <= fog_end_reg - 32'(z1_reg);
            dd_reg <= fog_end_reg - fog_start_reg;
            t0_reg <= tp0[50:16];
            t1_reg <= tp1[50:16];
        end
    end

    // linear divide and exponential units
    logic [F_W-1:0] q0, q1, e0, e1;

    ffl_div u_div0 (.clk(clk), .en(en), .num(n0_reg), .den(dd_reg), .quo(q0));
    ffl_div u_div1 (.clk(clk), .en(en), .num(n1_reg), .den(dd_reg), .quo(q1));
    ffl_exp u_exp0 (.clk(clk), .en(en), .t(t0_reg), .f(e0));
    ffl_exp u_exp1 (.clk(clk), .en(en), .t(t1_reg), .f(e1));

    // side lines keeping valid, class and exp results aligned to the divider
    logic     v_pipe_reg  [0:DIV_STAGES-1];
    lin_cls_t c0_pipe_reg [0:DIV_STAGES-1];
    lin_cls_t c1_pipe_reg [0:DIV_STAGES-1];
    logic [F_W-1:0] e0_pipe_reg [0:PAD_STAGES-1];
    logic [F_W-1:0] e1_pipe_reg [0:PAD_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                v_pipe_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            v_pipe_reg[0] <= vb_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                v_pipe_reg[i] <= v_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_pipe_reg[0] <= c0_reg;
            c1_pipe_reg[0] <= c1_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                c0_pipe_reg[i] <= c0_pipe_reg[i-1];
                c1_pipe_reg[i] <= c1_pipe_reg[i-1];
            end
            e0_pipe_reg[0] <= e0;
            e1_pipe_reg[0] <= e1;
            for (int i = 1; i < PAD_STAGES; i++)
            begin
                e0_pipe_reg[i] <= e0_pipe_reg[i-1];
                e1_pipe_reg[i] <= e1_pipe_reg[i-1];
            end
        end
    end

    // final stage: pick factor by mode, pack value and delta
    logic [F_W-1:0] f0, f1;
    logic signed [17:0] diff, dmag, dq, dsat;
    logic [11:0]    vraw;
    logic [10:0]    vfield;
    logic [WORD_W-1:0] word_next;
    logic           out_valid_reg;
    logic [WORD_W-1:0] table_word_reg;

    function automatic logic [F_W-1:0] pick(input logic [1:0] mode,
                                            input lin_cls_t c,
                                            input logic [F_W-1:0] q,
                                            input logic [F_W-1:0] e);
        logic [F_W-1:0] r;
        begin
            case (fog_mode_t'(mode))
                MODE_LINEAR:
                    r = (c == LIN_ONE) ? F_ONE : ((c == LIN_DIV) ? q : '0);
                MODE_EXP:
                    r = e;
                default:
                    r = '0;
            endcase
            return r;
        end
    endfunction

    assign f0 = pick(fog_mode_reg, c0_pipe_reg[DIV_STAGES-1], q0,
                     e0_pipe_reg[PAD_STAGES-1]);
    assign f1 = pick(fog_mode_reg, c1_pipe_reg[DIV_STAGES-1], q1,
                     e1_pipe_reg[PAD_STAGES-1]);

    always_comb
    begin
        diff = $signed({1'b0, f1}) - $signed({1'b0, f0});
        // divide by 32 truncating toward zero
        dmag = diff[17] ? -diff : diff;
        dq   = diff[17] ? -(dmag >>> 5) : (dmag >>> 5);
        if (dq < DELTA_MIN)
            dsat = DELTA_MIN;
        else if (dq > DELTA_MAX)
            dsat = DELTA_MAX;
        else
            dsat = dq;
        vraw   = f0[16:5];
        vfield = (vraw > 12'(VAL_MAX)) ? VAL_MAX : vraw[10:0];
        word_next = {vfield, dsat[VAL_SHIFT-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_pipe_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            table_word_reg <= word_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign table_word = table_word_reg;

    // a held result keeps the input side stalled
    a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input not stalled while result held");

    // a request accepted shows up one stage in
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> va_reg)
        else $error("accepted request lost at stage a");

    // disabled fog gives all-zero words
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fog_mode_reg[1]) |-> (table_word == '0))
        else $error("nonzero word with fog disabled");

    // linear fog never falls toward the near plane
    a_linear_rising: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fog_mode_reg == MODE_LINEAR) |-> !table_word[VAL_SHIFT-1])
        else $error("negative delta in linear mode");

endmodule

/* dv/fog_factor_lut_entry_chk.sv */
`timescale 1ns / 100ps
// fog_factor_lut_entry_chk: watches the request and result channels of the fog table block,
// predicts each table word and compares it with what comes out
// depends on ffl_pkg
module fog_factor_lut_entry_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [6:0]  entry_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [23:0] table_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          words_pending
);
    import ffl_pkg::*;

    localparam longint unsigned ENTRIES = 128;

    logic [1:0]  mode_q;
    logic [31:0] start_q;
    logic [31:0] end_q;
    logic [23:0] density_q;
    logic [23:0] word_queue[$];

    function automatic longint unsigned eye_z(input longint unsigned d);
        return (64'd2000 * ENTRIES * 64'd65536) / (64'd19999 * d + ENTRIES);
    endfunction

    function automatic longint unsigned pow2_entry(input int j);
        longint unsigned tab[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                     46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
        return tab[j];
    endfunction

    function automatic longint unsigned decay(input longint unsigned t);
        longint unsigned u, n, a, tl, p;
        u = (t * 64'd94548) >> 16;
        n = u >> 16;
        if (n >= 17)
            return 0;
        a = ((u & 64'hFFF) * 64'd45426) >> 16;
        tl = 64'd65536 - a + ((a * a) >> 17);
        p = (pow2_entry(int'((u >> 12) & 64'hF)) * tl) >> 16;
        return p >> n;
    endfunction

    function automatic longint unsigned fog_at(input longint unsigned z);
        longint unsigned st, en;
        st = start_q;
        en = end_q;
        if (mode_q == MODE_LINEAR)
        begin
            if (z < st)
                return 65536;
            if (z > en)
                return 0;
            if (en <= st)
                return 0;
            return ((en - z) * 64'd65536) / (en - st);
        end
        if (mode_q == MODE_EXP)
            return decay((longint'(density_q) * z) >> 16);
        return 0;
    endfunction

    function automatic logic [23:0] table_word_for(input logic [6:0] k);
        longint unsigned f0, f1, v;
        longint diff, d;
        logic [12:0] dbits;
        f0 = fog_at(eye_z(k));
        f1 = fog_at(eye_z(longint'(k) + 1));
        v = f0 >> 5;
        if (v > 64'h7FF)
            v = 64'h7FF;
        diff = longint'(f1) - longint'(f0);
        d = (diff >= 0) ? diff / 32 : -((-diff) / 32);
        if (d < -4096)
            d = -4096;
        else if (d > 4095)
            d = 4095;
        dbits = d[12:0];
        return {v[10:0], dbits};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q <= MODE_LINEAR;
            start_q <= 32'd0;
            end_q <= 32'd65536;
            density_q <= 24'd65536;
            fail_count <= 0;
            words_pending <= 0;
            word_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:    mode_q <= cfg_data[1:0];
                    REG_START:   start_q <= cfg_data;
                    REG_END:     end_q <= cfg_data;
                    REG_DENSITY: density_q <= cfg_data[23:0];
                    default:     mode_q <= mode_q;
                endcase
            end
            if (in_valid && !in_stall)
                word_queue.push_back(table_word_for(entry_index));
            if (out_valid && !out_stall)
            begin
                if (word_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected table word %h", table_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (word_queue[0] !== table_word)
                    begin
                        if (fail_count < 10)
                            $display("table_word mismatch: expected %h actual %h",
                                     word_queue[0], table_word);
                        fail_count <= fail_count + 1;
                    end
                    void'(word_queue.pop_front());
                end
            end
            words_pending <= word_queue.size();
        end
    end
endmodule

/* dv/fog_factor_lut_entry_tb.sv */
`timescale 1ns / 100ps
// fog_factor_lut_entry_tb: stimulus and verdict for the fog table entry block
// depends on ffl_pkg, the block and fog_factor_lut_entry_chk
module fog_factor_lut_entry_tb;
    import ffl_pkg::*;

    // pipeline depth given for the block, used for the drain before each setting load and at the end
    localparam int PIPE_LAT = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [6:0]  entry_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] table_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_MODE;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          words_pending;

    always #6 clk = ~clk;

    fog_factor_lut_entry i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .entry_index(entry_index),
        .out_valid(out_valid), .out_stall(out_stall), .table_word(table_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fog_factor_lut_entry_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .entry_index(entry_index),
        .out_valid(out_valid), .out_stall(out_stall), .table_word(table_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output stall: phases with none, others with random stall of varied length
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(20, 120);
            if ($urandom_range(0, 3) == 0)
                repeat (n) @(posedge clk) out_stall <= 1'b0;
            else
                repeat (n)
                begin
                    @(posedge clk);
                    out_stall <= (gap_len() != 0);
                end
        end
    end

    // one request; valid held while stalled, left high so requests can follow back to back
    task automatic send_index(input logic [6:0] k, input bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        entry_index <= k;
        do @(posedge clk); while (in_stall);
    endtask

    // register write; only ever called with the pipeline empty
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic load_setting(input logic [1:0] m, input logic [31:0] s,
                                input logic [31:0] e, input logic [23:0] dn);
        wait_empty();
        write_reg(REG_MODE, {30'd0, m});
        write_reg(REG_START, s);
        write_reg(REG_END, e);
        write_reg(REG_DENSITY, {8'd0, dn});
        cfg_valid <= 1'b0;
    endtask

    // start/end spread over the eye-distance range, which reaches 2000.0 in Q16.16
    function automatic logic [31:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h0010_0000);
            3: return $urandom_range(0, 32'h07D0_0000);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [31:0] s, e;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset setting at both edges of the table, next to the first entry and in the middle
        send_index(7'd0, 0);
        send_index(7'd127, 0);
        send_index(7'd1, 0);
        send_index(7'd64, 0);
        // linear over the full distance range, then an empty linear range
        load_setting(MODE_LINEAR, 32'd0, 32'h07D0_0000, 24'd0);
        send_index(7'd0, 0);
        send_index(7'd127, 0);
        send_index(7'd3, 0);
        load_setting(MODE_LINEAR, 32'h0010_0000, 32'h0010_0000, 24'hFF_FFFF);
        send_index(7'd0, 0);
        send_index(7'd50, 0);
        send_index(7'd127, 0);
        // start and end at the register extremes
        load_setting(MODE_LINEAR, 32'hFFFF_FFFF, 32'h0, 24'd1);
        send_index(7'd10, 0);
        load_setting(MODE_LINEAR, 32'h0, 32'hFFFF_FFFF, 24'd1);
        send_index(7'd0, 0);
        send_index(7'd127, 0);
        // exponential: smallest, unit and largest density
        load_setting(MODE_EXP, 32'h0, 32'h0, 24'd0);
        send_index(7'd0, 0);
        load_setting(MODE_EXP, 32'h0, 32'h0, 24'd65536);
        send_index(7'd0, 0);
        send_index(7'd127, 0);
        load_setting(MODE_EXP, 32'h0, 32'h0, 24'hFF_FFFF);
        send_index(7'd127, 0);
        send_index(7'd0, 0);
        // disabled fog and the unused mode code
        load_setting(MODE_OFF, 32'h0, 32'h0010_0000, 24'd100);
        send_index(7'd5, 0);
        load_setting(MODE_SPARE, 32'h0, 32'h0010_0000, 24'd100);
        send_index(7'd5, 0);

        // random phases, each under a fresh setting
        for (int ph = 0; ph < 16; ph++)
        begin
            s = rand_dist();
            e = rand_dist();
            if ($urandom_range(0, 3) != 0 && s > e)
            begin
                logic [31:0] t;
                t = s;
                s = e;
                e = t;
            end
            load_setting(($urandom_range(0, 9) < 4) ? MODE_LINEAR :
                         ($urandom_range(0, 5) < 4) ? MODE_EXP :
                         ($urandom_range(0, 1) != 0) ? MODE_OFF : MODE_SPARE,
                         s, e, ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                                                              24'($urandom_range(0, 24'h6_0000)));
            for (int i = 0; i < 25; i++)
            begin
                send_index(7'($urandom_range(0, 127)), 1);
                // in every fourth phase the sender holds off midway until every result is back
                if (i == 12 && ph % 4 == 0)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (words_pending != 0);
                end
            end
        end

        wait_empty();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

/* fog_factor_lut_entry.f */
rtl/ffl_pkg.sv
rtl/ffl_div.sv
rtl/ffl_exp.sv
rtl/fog_factor_lut_entry.sv
dv/fog_factor_lut_entry_chk.sv
dv/fog_factor_lut_entry_tb.sv
